[sv/vbds_pkg.sv]
// shared types and codes for the 2x2x2 volume box downsampler
// no dependencies; imported by vbds_scan, vbds_accum, the top level, the checker and the testbench
package vbds_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_IN_DEPTH  = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WIDTH_REG_BITS = 9;
  localparam int DEPTH_BITS     = 16;

  // per-voxel control carried along the accumulate pipeline
  typedef struct packed {
    logic       first;   // opens a new block sum
    logic       last;    // closes the block, emits a result
    logic       done;    // last output voxel of the volume
    logic [1:0] wshift;  // log2 of weight from unit-size axes
  } vbds_flags_t;

endpackage

[sv/volume_box_downsample_2x.sv]
// 2x2x2 box-filter downsampler for a raster-order voxel stream
// a block result passes the input, sum read and result registers on its way to out_tvalid
// throughput: one voxel per cycle while results drain, set by the single read-modify-write
//   per voxel on the partial sum memory (read registered, last write forwarded)
// reset: sizes return to 1, position returns to the volume start; sum memory not cleared
// uses vbds_pkg, vbds_scan and vbds_accum
module volume_box_downsample_2x import vbds_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int VOXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data,
  // voxel input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VOXEL_BITS+7)/8)*8-1:0]       in_tdata,   // voxel
  // downsampled output stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((VOXEL_BITS+7)/8)*8-1:0]       out_tdata,  // mean_voxel
  output logic                                  out_tlast   // volume_done
);

  localparam int TDW = ((VOXEL_BITS + 7) / 8) * 8;
  localparam int XW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AXW = (XW > 1) ? XW - 1 : 1;
  localparam int AYW = (YW > 1) ? YW - 1 : 1;
  localparam int AW  = AXW + AYW;

  logic                  item_ready;
  logic                  push_valid;
  logic [AW-1:0]         push_addr;
  vbds_flags_t           push_flags;
  logic [VOXEL_BITS-1:0] res_mean;

  // position tracking and size registers
  vbds_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AXW        (AXW),
    .AYW        (AYW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item_ready (item_ready),
    .push_valid (push_valid),
    .push_addr  (push_addr),
    .push_flags (push_flags)
  );

  // block accumulation and result register
  vbds_accum #(
    .VOXEL_BITS (VOXEL_BITS),
    .AW         (AW)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (item_ready),
    .push_voxel (in_tdata[VOXEL_BITS-1:0]),
    .push_addr  (push_addr),
    .push_flags (push_flags),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_mean   (res_mean),
    .res_done   (out_tlast)
  );

  assign out_tdata = TDW'(res_mean);

endmodule

[sv/vbds_scan.sv]
// size registers and raster position tracking for the downsampler
// computes block address and block flags per input voxel; uses vbds_pkg
module vbds_scan import vbds_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AXW        = 7,
  parameter int AYW        = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      item_ready,
  output logic                      push_valid,
  output logic [AYW+AXW-1:0]        push_addr,
  output vbds_flags_t               push_flags
);

  localparam int XW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CXW = (XW + 1 > WIDTH_REG_BITS) ? XW + 1 : WIDTH_REG_BITS;
  localparam int CYW = (YW + 1 > WIDTH_REG_BITS) ? YW + 1 : WIDTH_REG_BITS;

  logic [WIDTH_REG_BITS-1:0] width_r, width_nxt;
  logic [WIDTH_REG_BITS-1:0] height_r, height_nxt;
  logic [DEPTH_BITS-1:0]     depth_r, depth_nxt;
  logic [XW-1:0]             col_r, col_nxt;
  logic [YW-1:0]             row_r, row_nxt;
  logic [DEPTH_BITS-1:0]     plane_r, plane_nxt;

  logic [CXW-1:0]        w_ext;
  logic [CYW-1:0]        h_ext;
  logic [XW:0]           w_eff;
  logic [YW:0]           h_eff;
  logic [DEPTH_BITS-1:0] d_eff;
  logic [XW-1:0]         ow;
  logic [YW-1:0]         oh;
  logic [DEPTH_BITS-1:0] od;
  logic                  w1, h1, d1;
  logic                  inx, iny, inz;
  logic [XW-1:0]         ox;
  logic [YW-1:0]         oy;
  logic [DEPTH_BITS-1:0] oz;
  logic                  accept, cfg_hit;
  logic [XW:0]           col_inc;
  logic [YW:0]           row_inc;
  logic [DEPTH_BITS:0]   plane_inc;

  assign cfg_ready = 1'b1;
  assign in_tready = item_ready;
  assign accept    = in_tvalid & item_ready;
  assign cfg_hit   = cfg_valid & ((cfg_index == REG_IN_WIDTH) |
                     (cfg_index == REG_IN_HEIGHT) | (cfg_index == REG_IN_DEPTH));

  // effective sizes: zero counts as one, width and height saturate
  always_comb begin
    w_ext = CXW'(width_r);
    h_ext = CYW'(height_r);
    if (w_ext == '0) w_eff = (XW+1)'(1);
    else if (w_ext > CXW'(MAX_WIDTH)) w_eff = (XW+1)'(MAX_WIDTH);
    else w_eff = (XW+1)'(w_ext);
    if (h_ext == '0) h_eff = (YW+1)'(1);
    else if (h_ext > CYW'(MAX_HEIGHT)) h_eff = (YW+1)'(MAX_HEIGHT);
    else h_eff = (YW+1)'(h_ext);
    d_eff = (depth_r == '0) ? DEPTH_BITS'(1) : depth_r;
  end

  // output sizes and unit-axis flags
  assign w1 = (w_eff == (XW+1)'(1));
  assign h1 = (h_eff == (YW+1)'(1));
  assign d1 = (d_eff == DEPTH_BITS'(1));
  assign ow = w1 ? XW'(1) : XW'(w_eff >> 1);
  assign oh = h1 ? YW'(1) : YW'(h_eff >> 1);
  assign od = d1 ? DEPTH_BITS'(1) : (d_eff >> 1);

  // trailing odd column, row or plane is dropped
  assign inx = w1 | ({1'b0, col_r} < {ow, 1'b0});
  assign iny = h1 | ({1'b0, row_r} < {oh, 1'b0});
  assign inz = d1 | ({1'b0, plane_r} < {od, 1'b0});

  assign ox = col_r >> 1;
  assign oy = row_r >> 1;
  assign oz = plane_r >> 1;

  // block address and flags for the current voxel
  always_comb begin
    push_valid       = accept & inx & iny & inz;
    push_addr        = {AYW'(oy), AXW'(ox)};
    push_flags.first = ~col_r[0] & ~row_r[0] & ~plane_r[0];
    push_flags.last  = (w1 | col_r[0]) & (h1 | row_r[0]) & (d1 | plane_r[0]);
    push_flags.done  = (ox == ow - XW'(1)) & (oy == oh - YW'(1)) &
                       (oz == od - DEPTH_BITS'(1));
    push_flags.wshift = 2'({1'b0, w1}) + 2'({1'b0, h1}) + 2'({1'b0, d1});
  end

  // raster position advance and size register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    plane_nxt  = plane_r;
    col_inc    = {1'b0, col_r} + (XW+1)'(1);
    row_inc    = {1'b0, row_r} + (YW+1)'(1);
    plane_inc  = {1'b0, plane_r} + (DEPTH_BITS+1)'(1);
    if (cfg_hit) begin
      case (cfg_index)
        REG_IN_WIDTH:  width_nxt  = cfg_data[WIDTH_REG_BITS-1:0];
        REG_IN_HEIGHT: height_nxt = cfg_data[WIDTH_REG_BITS-1:0];
        REG_IN_DEPTH:  depth_nxt  = cfg_data[DEPTH_BITS-1:0];
        default: ;
      endcase
      col_nxt   = '0;
      row_nxt   = '0;
      plane_nxt = '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        if (row_inc >= h_eff) begin
          row_nxt = '0;
          if (plane_inc >= {1'b0, d_eff}) plane_nxt = '0;
          else plane_nxt = plane_inc[DEPTH_BITS-1:0];
        end else begin
          row_nxt = row_inc[YW-1:0];
        end
      end else begin
        col_nxt = col_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_BITS'(1);
      height_r <= WIDTH_REG_BITS'(1);
      depth_r  <= DEPTH_BITS'(1);
      col_r    <= '0;
      row_r    <= '0;
      plane_r  <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      plane_r  <= plane_nxt;
    end
  end

endmodule

[sv/vbds_accum.sv]
// block sum pipeline: input register, sum memory read, accumulate, result register
// holds the per-plane partial sums with write forwarding; uses vbds_pkg
module vbds_accum import vbds_pkg::*; #(
  parameter int VOXEL_BITS = 16,
  parameter int AW         = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [VOXEL_BITS-1:0] push_voxel,
  input  logic [AW-1:0]         push_addr,
  input  vbds_flags_t           push_flags,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [VOXEL_BITS-1:0] res_mean,
  output logic                  res_done
);

  localparam int SW = VOXEL_BITS + 3;

  logic [SW-1:0] sum_mem [2**AW];

  logic                  s1_valid_r, s1_valid_nxt;
  logic [VOXEL_BITS-1:0] s1_voxel_r;
  logic [AW-1:0]         s1_addr_r;
  vbds_flags_t           s1_flags_r;
  logic                  s2_valid_r, s2_valid_nxt;
  logic [VOXEL_BITS-1:0] s2_voxel_r;
  logic [AW-1:0]         s2_addr_r;
  vbds_flags_t           s2_flags_r;
  logic [SW-1:0]         rd_data_r;
  logic                  wr_valid_r;
  logic [AW-1:0]         wr_addr_r;
  logic [SW-1:0]         wr_data_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [VOXEL_BITS-1:0] out_mean_r;
  logic                  out_done_r;

  logic          out_free, s2_go, s2_open, s1_go, s1_open;
  logic [SW-1:0] old_sum, contrib, new_sum;

  // stall chain from the result side back to the input side
  assign out_free   = ~out_valid_r | res_ready;
  assign s2_go      = s2_valid_r & (~s2_flags_r.last | out_free);
  assign s2_open    = ~s2_valid_r | s2_go;
  assign s1_go      = s1_valid_r & s2_open;
  assign s1_open    = ~s1_valid_r | s1_go;
  assign push_ready = s1_open;

  // accumulate with forwarding of the most recent write
  always_comb begin
    old_sum = (wr_valid_r && wr_addr_r == s2_addr_r) ? wr_data_r : rd_data_r;
    contrib = SW'(s2_voxel_r) << s2_flags_r.wshift;
    new_sum = s2_flags_r.first ? contrib : old_sum + contrib;
  end

  // valid bits of the stages
  always_comb begin
    s1_valid_nxt  = s1_open ? push_valid : s1_valid_r;
    s2_valid_nxt  = s2_open ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_valid_r;
    if (s2_go && s2_flags_r.last) out_valid_nxt = 1'b1;
    else if (res_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wr_valid_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_go) wr_valid_r <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_open) begin
      s1_voxel_r <= push_voxel;
      s1_addr_r  <= push_addr;
      s1_flags_r <= push_flags;
    end
    if (s2_open) begin
      s2_voxel_r <= s1_voxel_r;
      s2_addr_r  <= s1_addr_r;
      s2_flags_r <= s1_flags_r;
    end
    if (s2_go) begin
      wr_addr_r <= s2_addr_r;
      wr_data_r <= new_sum;
    end
    if (s2_go && s2_flags_r.last) begin
      out_mean_r <= new_sum[SW-1:3];
      out_done_r <= s2_flags_r.done;
    end
  end

  // partial sum memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (s1_go) rd_data_r <= sum_mem[s1_addr_r];
    if (s2_go) sum_mem[s2_addr_r] <= new_sum;
  end

  assign res_valid = out_valid_r;
  assign res_mean  = out_mean_r;
  assign res_done  = out_done_r;

endmodule

[verif/volume_box_downsample_2x_checker.sv]
`timescale 1ns / 1ps
// checker for volume_box_downsample_2x: keeps its own sizes, scan position and partial
// block sums, predicts every block mean and compares it with out_tdata; uses vbds_pkg
module volume_box_downsample_2x_checker import vbds_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int VOXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((VOXEL_BITS+7)/8)*8-1:0]     in_tdata,   // voxel
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [((VOXEL_BITS+7)/8)*8-1:0]     out_tdata,  // mean_voxel
  input  logic                                out_tlast,  // volume_done
  output int                                  fail_count,
  output int                                  pending
);

  localparam int SUM_BITS  = VOXEL_BITS + 3;
  localparam int SUM_COLS  = MAX_WIDTH / 2;
  localparam int SUM_ROWS  = MAX_HEIGHT / 2;
  localparam int MAX_DEPTH = 65535;

  typedef struct packed {
    logic [VOXEL_BITS-1:0] mean;
    logic                  done;
  } block_mean_t;

  block_mean_t expected_means[$];

  logic [WIDTH_REG_BITS-1:0] width_reg;
  logic [WIDTH_REG_BITS-1:0] height_reg;
  logic [DEPTH_BITS-1:0]     depth_reg;
  int unsigned               x_at, y_at, z_at;
  logic [SUM_BITS-1:0]       block_sums [SUM_ROWS*SUM_COLS];
  int                        fail_tally = 0;
  int                        results_seen = 0;

  // zero acts as one, oversize saturates
  function automatic int unsigned clamp_size(int unsigned raw, int unsigned ceiling);
    if (raw == 0) return 1;
    if (raw > ceiling) return ceiling;
    return raw;
  endfunction

  function automatic int unsigned halved(int unsigned dim);
    return (dim == 1) ? 1 : dim / 2;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
    fail_tally++;
  endtask

  // register write: any size register restarts the volume
  task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
    case (index)
      REG_IN_WIDTH:  width_reg  = value[WIDTH_REG_BITS-1:0];
      REG_IN_HEIGHT: height_reg = value[WIDTH_REG_BITS-1:0];
      REG_IN_DEPTH:  depth_reg  = value[DEPTH_BITS-1:0];
      default:       return;
    endcase
    x_at = 0;
    y_at = 0;
    z_at = 0;
  endtask

  // fold one voxel into its block sum, queue the mean when the block closes
  task automatic absorb_voxel(input logic [VOXEL_BITS-1:0] voxel);
    int unsigned         w, h, d, ow, oh, od, ox, oy, oz, slot, unit_axes;
    logic                opens, closes;
    logic [SUM_BITS-1:0] share;
    block_mean_t         result;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    d = clamp_size(depth_reg, MAX_DEPTH);
    ow = halved(w);
    oh = halved(h);
    od = halved(d);
    if ((w == 1 || x_at < 2 * ow) && (h == 1 || y_at < 2 * oh) &&
        (d == 1 || z_at < 2 * od)) begin
      ox = x_at >> 1;
      oy = y_at >> 1;
      oz = z_at >> 1;
      // a unit-size axis counts its single voxel twice
      unit_axes = 0;
      if (w == 1) unit_axes++;
      if (h == 1) unit_axes++;
      if (d == 1) unit_axes++;
      share = SUM_BITS'(voxel) << unit_axes;
      opens = (x_at % 2 == 0) && (y_at % 2 == 0) && (z_at % 2 == 0);
      closes = (w == 1 || x_at % 2 == 1) && (h == 1 || y_at % 2 == 1) &&
               (d == 1 || z_at % 2 == 1);
      slot = (oy % SUM_ROWS) * SUM_COLS + (ox % SUM_COLS);
      if (opens) block_sums[slot] = share;
      else block_sums[slot] = block_sums[slot] + share;
      if (closes) begin
        result.mean = VOXEL_BITS'(block_sums[slot] >> 3);
        result.done = (ox == ow - 1) && (oy == oh - 1) && (oz == od - 1);
        expected_means.push_back(result);
      end
    end
    // raster advance, wrapping into the next volume
    x_at++;
    if (x_at >= w) begin
      x_at = 0;
      y_at++;
      if (y_at >= h) begin
        y_at = 0;
        z_at++;
        if (z_at >= d) z_at = 0;
      end
    end
  endtask

  task automatic check_result(input logic [VOXEL_BITS-1:0] mean, input logic done);
    block_mean_t want;
    results_seen++;
    if (expected_means.size() == 0) begin
      report_mismatch($sformatf("unexpected result mean %h done %b", mean, done));
      return;
    end
    want = expected_means.pop_front();
    if (mean !== want.mean)
      report_mismatch($sformatf("mean_voxel %h, predicted %h", mean, want.mean));
    if (done !== want.done)
      report_mismatch($sformatf("volume_done %b, predicted %b", done, want.done));
  endtask

  // watch all three channels on each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 1;
      height_reg = 1;
      depth_reg  = 1;
      x_at = 0;
      y_at = 0;
      z_at = 0;
      expected_means.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata[VOXEL_BITS-1:0], out_tlast);
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) absorb_voxel(in_tdata[VOXEL_BITS-1:0]);
    end
    pending    <= expected_means.size();
    fail_count <= fail_tally;
  end

endmodule

[verif/volume_box_downsample_2x_tb.sv]
`timescale 1ns / 1ps
// testbench top for volume_box_downsample_2x: clock, reset, voxel and register
// stimulus, result backpressure and verdict; uses vbds_pkg and the checker module
module volume_box_downsample_2x_tb;
  import vbds_pkg::*;

  localparam int VOXEL_BITS    = 16;
  localparam int DATA_BITS     = ((VOXEL_BITS + 7) / 8) * 8;
  localparam int RANDOM_VOXELS = 900;
  localparam int MAX_GAP       = 17;
  localparam int SETTLE_CYCLES = 8;
  localparam longint LIMIT_CYCLES = 400000;
  // index with no register behind it
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [DATA_BITS-1:0]      in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [DATA_BITS-1:0]      out_tdata;
  logic                      out_tlast;
  int                        fail_count;
  int                        pending;

  bit                        in_calm = 1'b0;
  int                        random_voxels = 0;

  volume_box_downsample_2x #(.VOXEL_BITS(VOXEL_BITS)) dut (.*);

  volume_box_downsample_2x_checker #(.VOXEL_BITS(VOXEL_BITS)) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls per result, with calm stretches
  initial begin : result_drain
    int unsigned gap;
    int unsigned calm_left;
    calm_left = 0;
    forever begin
      if (calm_left == 0 && $urandom_range(0, 7) == 0) calm_left = $urandom_range(10, 40);
      gap = (calm_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (calm_left > 0) calm_left--;
    end
  end

  task automatic send_voxel(input logic [VOXEL_BITS-1:0] voxel);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_BITS'(voxel);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending, let every predicted result drain, then a few quiet cycles
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write all three sizes in a rotated order
  task automatic configure(input logic [CFG_DATA_BITS-1:0] w_data,
                           input logic [CFG_DATA_BITS-1:0] h_data,
                           input logic [CFG_DATA_BITS-1:0] d_data);
    logic [CFG_INDEX_BITS-1:0] size_regs [3];
    logic [CFG_DATA_BITS-1:0]  size_vals [3];
    int unsigned               rot;
    size_regs = '{REG_IN_WIDTH, REG_IN_HEIGHT, REG_IN_DEPTH};
    size_vals = '{w_data, h_data, d_data};
    rot = $urandom_range(0, 2);
    settle();
    for (int k = 0; k < 3; k++) write_reg(size_regs[(k + rot) % 3], size_vals[(k + rot) % 3]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VOXEL_BITS-1:0] random_voxel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VOXEL_BITS'($urandom);
    endcase
  endfunction

  // width and height ignore the upper data bits, so fill them at random now and then
  function automatic logic [CFG_DATA_BITS-1:0] plane_size_data(input int unsigned raw);
    logic [CFG_DATA_BITS-1:0] value;
    value = CFG_DATA_BITS'(raw);
    if ($urandom_range(0, 1) == 1)
      value[CFG_DATA_BITS-1:WIDTH_REG_BITS] = (CFG_DATA_BITS-WIDTH_REG_BITS)'($urandom);
    return value;
  endfunction

  // one volume setting and a stream of voxels; the first three take the size extremes
  task automatic random_phase(input int phase);
    int unsigned w, h, d, vol, count, pause_at, which;
    logic [CFG_DATA_BITS-1:0] d_data;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 6);
    d = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) w = 0;
    if ($urandom_range(0, 9) == 0) h = 0;
    if ($urandom_range(0, 9) == 0) d = 0;
    d_data = CFG_DATA_BITS'(d);
    vol = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * ((d == 0) ? 1 : d);
    count = vol * $urandom_range(1, 2);
    if ($urandom_range(0, 3) == 0) count = $urandom_range(1, vol);
    if (phase < 3 || $urandom_range(0, 11) == 0) begin
      which = (phase < 3) ? phase : $urandom_range(0, 2);
      case (which)
        // full-width line, oversize values saturate
        0: begin
          w = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(256, 511);
          h = 1;
          d = 1;
          d_data = CFG_DATA_BITS'(1);
          count = 256;
        end
        // full-height column
        1: begin
          w = 1;
          h = ($urandom_range(0, 2) == 0) ? 511 : 256;
          d = 1;
          d_data = CFG_DATA_BITS'(1);
          count = 256;
        end
        // deepest or random-depth volume, only its start is streamed
        default: begin
          w = 1;
          h = 1;
          d_data = ($urandom_range(0, 1) == 0) ? 16'hFFFF : CFG_DATA_BITS'($urandom);
          count = $urandom_range(60, 150);
        end
      endcase
    end
    configure(plane_size_data(w), plane_size_data(h), d_data);
    in_calm = ($urandom_range(0, 3) == 0);
    pause_at = (count > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : 0;
    for (int k = 0; k < count; k++) begin
      // drain mid-volume; the spare index must not move the scan position
      if (pause_at != 0 && k == pause_at) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
          cfg_valid <= 1'b0;
        end
      end
      send_voxel(random_voxel());
      random_voxels++;
    end
  endtask

  initial begin : stimulus
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes 1x1x1: every voxel is its own block, weighted eight times
    send_voxel(16'h0000);
    send_voxel(16'hFFFF);
    // zero sizes behave as one
    configure(16'd0, 16'd0, 16'd0);
    send_voxel(16'h5555);
    send_voxel(16'hAAAA);
    // full block of maximum voxels
    configure(16'd2, 16'd2, 16'd2);
    repeat (8) send_voxel(16'hFFFF);
    // trailing odd column dropped
    configure(16'd3, 16'd1, 16'd1);
    send_voxel(16'hFFFF);
    send_voxel(16'h8000);
    send_voxel(16'h1234);
    // two unit axes: x and z, then x and y
    configure(16'd1, 16'd2, 16'd1);
    send_voxel(16'h0001);
    send_voxel(16'hFFFE);
    configure(16'd1, 16'd1, 16'd2);
    send_voxel(16'h7FFF);
    send_voxel(16'h8001);

    phase = 0;
    while (random_voxels < RANDOM_VOXELS) begin
      random_phase(phase);
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
sv/vbds_pkg.sv
sv/vbds_scan.sv
sv/vbds_accum.sv
sv/volume_box_downsample_2x.sv
verif/volume_box_downsample_2x_checker.sv
verif/volume_box_downsample_2x_tb.sv
